FILE: sv/dcmrle_pkg.sv
// ----------------------------------------------------------------------------
// dcmrle_pkg
// Shared types and constants for the RLE frame decoder: the command that the
// front end queues for the back end, error codes and fixed header layout.
// ----------------------------------------------------------------------------
package dcmrle_pkg;

   localparam int HEADER_BYTES = 64;
   localparam int OUT_LANES    = 4;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ERR_NONE         = 2'd0,
      ERR_SEG_COUNT    = 2'd1,
      ERR_FIRST_OFFSET = 2'd2
   } err_type;

   // count: bytes to emit (1 literal, run length for replicate, 0 status only)
   typedef struct packed {
      logic [7:0] byte_value;
      logic [7:0] count;
      logic [3:0] segment;
      err_type    error;
      logic       frame_last;
   } cmd_type;

   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic [3:0]  segment_number;
      logic [1:0]  error_code;
      logic        run_last;
      logic        frame_done;
   } rsp_type;

endpackage

FILE: sv/dcmrle_if.sv
// ----------------------------------------------------------------------------
// dcmrle channel interfaces
// Valid/ready channels for encoded input bytes and packed decoded results.
// ----------------------------------------------------------------------------
interface dcmrle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       frame_last;

   modport source (output valid, output byte_value, output frame_last, input ready);
   modport sink   (input valid, input byte_value, input frame_last, output ready);
endinterface

interface dcmrle_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] data_word;
   logic [2:0]  byte_count;
   logic [3:0]  segment_number;
   logic [1:0]  error_code;
   logic        run_last;
   logic        frame_done;

   modport source (output valid, output data_word, output byte_count,
                   output segment_number, output error_code, output run_last,
                   output frame_done, input ready);
   modport sink   (input valid, input data_word, input byte_count,
                   input segment_number, input error_code, input run_last,
                   input frame_done, output ready);
endinterface

FILE: sv/dicom_rle_frame_decoder_core.sv
// ----------------------------------------------------------------------------
// dicom_rle_frame_decoder_core
// RLE lossless (PackBits) frame decoder: header parse, segment tracking and
// packed output of decoded bytes.
// ----------------------------------------------------------------------------
// Feed one encoded frame byte per transaction, header included, frame_last on
// the final byte. Header and literal bytes are taken at one per cycle while
// the queue has room and no segment step is pending; a replicate run of n
// bytes leaves the output side as ceil(n/OUT_LANES) packed words, and input
// stalls once the four-entry command queue between the parser and the output
// packer fills. Each segment boundary crossed holds off the byte at that
// position while the parser steps to the next segment, since the parser
// compares one stored offset per cycle. Results pass through the command
// queue and the output register. A bad segment count or first offset gives
// one status result with an error code, and the rest of that frame is dropped until frame_last.
// ----------------------------------------------------------------------------
module dicom_rle_frame_decoder_core #(
   parameter int MAX_SEGMENTS = 15
) (
   input  logic         clock,
   input  logic         reset,
   dcmrle_req_if.sink   req_if,
   dcmrle_rsp_if.source rsp_if
);

   logic                q_full;
   logic                push;
   dcmrle_pkg::cmd_type push_cmd;
   logic                pop;
   logic                not_empty;
   dcmrle_pkg::cmd_type head;

   dcmrle_front #(
      .MAX_SEGMENTS (MAX_SEGMENTS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   dcmrle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head)
   );

   dcmrle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_if    (rsp_if)
   );

endmodule

FILE: sv/dcmrle_front.sv
// ----------------------------------------------------------------------------
// dcmrle_front
// Header parser and PackBits control decoder. Each accepted byte yields at
// most one command for the back end.
// ----------------------------------------------------------------------------
module dcmrle_front #(
   parameter int MAX_SEGMENTS = 15
) (
   input  logic                clock,
   input  logic                reset,
   dcmrle_req_if.sink          req_if,
   input  logic                q_full,
   output logic                push,
   output dcmrle_pkg::cmd_type push_cmd
);

   localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

   typedef enum logic [1:0] {
      PH_HEADER  = 2'd0,
      PH_CONTROL = 2'd1,
      PH_LITERAL = 2'd2,
      PH_REPEAT  = 2'd3
   } phase_type;

   logic [31:0] pos_ff, pos_in;
   logic [31:0] asm_ff, asm_in;
   logic [3:0]  total_ff, total_in;
   logic [3:0]  cur_ff, cur_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  run_ff, run_in;
   logic        failed_ff, failed_in;

   logic [31:0] off_ff [MAX_SEGMENTS];
   logic             off_we;
   logic [IDX_W-1:0] off_wa;

   logic [3:0]  cur_nxt;
   logic        adv_pending;
   logic        accept;
   logic [7:0]  b;
   logic [31:0] hdr_word;
   logic [3:0]  hdr_idx;
   logic        hdr_err;
   dcmrle_pkg::cmd_type cmd;
   logic        cmd_vld;

   assign b        = req_if.byte_value;
   assign cur_nxt  = cur_ff + 4'd1;
   assign hdr_word = {b, asm_ff[31:8]};
   assign hdr_idx  = pos_ff[5:2];

   // one segment step per cycle; the byte waits until the segment is settled
   assign adv_pending = (phase_ff != PH_HEADER) && !failed_ff
                        && (cur_nxt < total_ff)
                        && ({1'b0, cur_nxt} < 5'(MAX_SEGMENTS))
                        && (pos_ff >= off_ff[cur_nxt[IDX_W-1:0]]);

   assign req_if.ready = !adv_pending && !q_full;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      pos_in    = pos_ff;
      asm_in    = asm_ff;
      total_in  = total_ff;
      cur_in    = cur_ff;
      phase_in  = phase_ff;
      run_in    = run_ff;
      failed_in = failed_ff;
      off_we    = 1'b0;
      off_wa    = IDX_W'(hdr_idx - 4'd1);
      hdr_err   = 1'b0;
      cmd_vld   = 1'b0;
      cmd       = '{byte_value: b, count: 8'd0, segment: cur_ff,
                    error: dcmrle_pkg::ERR_NONE, frame_last: req_if.frame_last};

      if (adv_pending) begin
         cur_in   = cur_nxt;
         phase_in = PH_CONTROL;
         run_in   = '0;
      end else if (accept) begin
         if (!failed_ff) begin
            case (phase_ff)
               PH_HEADER: begin
                  asm_in = hdr_word;
                  if (pos_ff[1:0] == 2'd3) begin
                     if (hdr_idx == 4'd0) begin
                        if (hdr_word == 32'd0 || hdr_word > 32'(MAX_SEGMENTS)) begin
                           hdr_err   = 1'b1;
                           cmd.error = dcmrle_pkg::ERR_SEG_COUNT;
                        end else begin
                           total_in = hdr_word[3:0];
                        end
                     end else if ({1'b0, hdr_idx - 4'd1} < 5'(MAX_SEGMENTS)) begin
                        off_we = 1'b1;
                        if (hdr_idx == 4'd1 && hdr_word != 32'(dcmrle_pkg::HEADER_BYTES)) begin
                           hdr_err   = 1'b1;
                           cmd.error = dcmrle_pkg::ERR_FIRST_OFFSET;
                        end
                     end
                  end
                  if (hdr_err) begin
                     failed_in   = 1'b1;
                     cmd_vld     = 1'b1;
                     cmd.segment = '0;
                  end else if (pos_ff == 32'(dcmrle_pkg::HEADER_BYTES - 1)) begin
                     phase_in = PH_CONTROL;
                     cur_in   = '0;
                     run_in   = '0;
                  end
               end
               PH_CONTROL: begin
                  if (b < 8'd128) begin
                     run_in   = b + 8'd1;
                     phase_in = PH_LITERAL;
                  end else if (b > 8'd128) begin
                     run_in   = 8'(9'd257 - {1'b0, b});
                     phase_in = PH_REPEAT;
                  end
               end
               PH_LITERAL: begin
                  cmd_vld   = 1'b1;
                  cmd.count = 8'd1;
                  run_in    = run_ff - 8'd1;
                  if (run_ff == 8'd1) begin
                     phase_in = PH_CONTROL;
                  end
               end
               PH_REPEAT: begin
                  cmd_vld   = 1'b1;
                  cmd.count = run_ff;
                  run_in    = '0;
                  phase_in  = PH_CONTROL;
               end
               default: begin
                  phase_in = PH_HEADER;
               end
            endcase
         end

         pos_in = (pos_ff == '1) ? pos_ff : pos_ff + 32'd1;

         if (req_if.frame_last) begin
            if (!cmd_vld) begin
               cmd.count   = '0;
               cmd.segment = '0;
               cmd.error   = dcmrle_pkg::ERR_NONE;
            end
            cmd_vld   = 1'b1;
            pos_in    = '0;
            asm_in    = '0;
            total_in  = '0;
            cur_in    = '0;
            phase_in  = PH_HEADER;
            run_in    = '0;
            failed_in = 1'b0;
         end
      end
   end

   assign push     = accept && cmd_vld;
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         asm_ff    <= '0;
         total_ff  <= '0;
         cur_ff    <= '0;
         phase_ff  <= PH_HEADER;
         run_ff    <= '0;
         failed_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         asm_ff    <= asm_in;
         total_ff  <= total_in;
         cur_ff    <= cur_in;
         phase_ff  <= phase_in;
         run_ff    <= run_in;
         failed_ff <= failed_in;
      end
   end

   // segment offset table, written from each header's offset fields as they arrive
   always_ff @(posedge clock) begin
      if (off_we && accept) begin
         off_ff[off_wa] <= hdr_word;
      end
   end

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_if.frame_last |=> phase_ff == PH_HEADER && pos_ff == '0 && !failed_ff)
      else $error("frame state not cleared after last byte");

   a_adv_step: assert property (@(posedge clock) disable iff (reset)
      adv_pending |=> cur_ff == $past(cur_nxt) && phase_ff == PH_CONTROL)
      else $error("segment advance did not take one step");

   a_seg_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cur_ff} < 5'(MAX_SEGMENTS) || cur_ff == '0)
      else $error("current segment beyond table");

endmodule

FILE: sv/dcmrle_queue.sv
// ----------------------------------------------------------------------------
// dcmrle_queue
// Small command FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module dcmrle_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dcmrle_pkg::cmd_type push_cmd,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output dcmrle_pkg::cmd_type head
);

   dcmrle_pkg::cmd_type q_ff [dcmrle_pkg::QUEUE_DEPTH];
   logic [dcmrle_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [dcmrle_pkg::QCNT_W-1:0] count_ff;

   assign full      = (count_ff == dcmrle_pkg::QCNT_W'(dcmrle_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("push into full command queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty command queue");

endmodule

FILE: sv/dcmrle_back.sv
// ----------------------------------------------------------------------------
// dcmrle_back
// Executes queued commands: emits literal bytes, splits replicate runs into
// packed words of up to OUT_LANES bytes, and issues status results.
// ----------------------------------------------------------------------------
module dcmrle_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                not_empty,
   input  dcmrle_pkg::cmd_type head,
   output logic                pop,
   dcmrle_rsp_if.source        rsp_if
);

   localparam logic [7:0] LANES = 8'(dcmrle_pkg::OUT_LANES);

   logic                active_ff, active_in;
   dcmrle_pkg::cmd_type held_ff, held_in;
   logic                rsp_valid_ff, rsp_valid_in;
   dcmrle_pkg::rsp_type rsp_ff, rsp_in;

   dcmrle_pkg::cmd_type src;
   logic                src_vld;
   logic                out_free;
   logic                emit;
   logic [7:0]          chunk;
   logic [7:0]          rem_nxt;
   logic [31:0]         word;

   assign src      = active_ff ? held_ff : head;
   assign src_vld  = active_ff || not_empty;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign emit     = out_free && src_vld;
   assign pop      = out_free && !active_ff && not_empty;
   assign chunk    = (src.count < LANES) ? src.count : LANES;
   assign rem_nxt  = src.count - chunk;

   always_comb begin
      for (int i = 0; i < dcmrle_pkg::OUT_LANES; i++) begin
         word[8*i +: 8] = (8'(i) < chunk) ? src.byte_value : 8'd0;
      end
   end

   always_comb begin
      active_in    = active_ff;
      held_in      = held_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (emit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.data_word      = word;
         rsp_in.byte_count     = chunk[2:0];
         rsp_in.segment_number = src.segment;
         rsp_in.error_code     = src.error;
         rsp_in.run_last       = (rem_nxt == '0);
         rsp_in.frame_done     = (rem_nxt == '0) && src.frame_last;
         held_in               = src;
         held_in.count         = rem_nxt;
         active_in             = (rem_nxt != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      held_ff <= held_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.data_word      = rsp_ff.data_word;
   assign rsp_if.byte_count     = rsp_ff.byte_count;
   assign rsp_if.segment_number = rsp_ff.segment_number;
   assign rsp_if.error_code     = rsp_ff.error_code;
   assign rsp_if.run_last       = rsp_ff.run_last;
   assign rsp_if.frame_done     = rsp_ff.frame_done;

   a_status_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.byte_count == '0 |-> rsp_ff.run_last)
      else $error("status-only result not marked last");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.frame_done |-> rsp_ff.run_last)
      else $error("frame_done without run_last");

   a_no_pop_mid_run: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> !pop)
      else $error("queue popped while a run is still draining");

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dicom_rle_frame_decoder_core. Encoded frames
// (header plus PackBits segments, well-formed, broken and noisy) are fed
// through the request channel in random bursts. A behavioral decoder in the
// scoreboard predicts every packed result, and each result transaction is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SEG      = 15;
   localparam int LANES        = dcmrle_pkg::OUT_LANES;
   localparam int TOTAL_ITEMS  = 270;
   localparam int HOLD_CYCLES  = 400;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 20;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_CONTROL,
      PH_LITERAL,
      PH_REPEAT
   } phase_type;

   class rle_frame_scoreboard;
      dcmrle_pkg::rsp_type expected_words[$];
      int unsigned         fail_count;
      dcmrle_pkg::rsp_type held;
      bit                  held_valid;

      logic [31:0] pos;
      logic [31:0] hdr_word;
      logic [3:0]  seg_total;
      logic [31:0] seg_off [MAX_SEG];
      logic [3:0]  cur_seg;
      phase_type   phase;
      logic [7:0]  run_left;
      bit          dropping;

      function new();
         foreach (seg_off[i]) seg_off[i] = '0;
         fail_count = 0;
         held_valid = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         pos       = '0;
         hdr_word  = '0;
         seg_total = '0;
         cur_seg   = '0;
         phase     = PH_HEADER;
         run_left  = '0;
         dropping  = 0;
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      // the newest result is held back so run_last/frame_done can be set on it
      function void stage(logic [31:0] word, logic [2:0] cnt, logic [3:0] seg,
                          dcmrle_pkg::err_type err);
         if (held_valid) expected_words = {expected_words, held};
         held.data_word      = word;
         held.byte_count     = cnt;
         held.segment_number = seg;
         held.error_code     = err;
         held.run_last       = 1'b0;
         held.frame_done     = 1'b0;
         held_valid          = 1;
      endfunction

      function void header_byte(logic [7:0] b);
         int unsigned idx;
         hdr_word = {b, hdr_word[31:8]};
         if (pos[1:0] == 2'd3) begin
            idx = pos >> 2;
            if (idx == 0) begin
               if (hdr_word == 0 || hdr_word > MAX_SEG) begin
                  dropping = 1;
                  stage('0, '0, '0, dcmrle_pkg::ERR_SEG_COUNT);
                  return;
               end
               seg_total = hdr_word[3:0];
            end else if (idx <= MAX_SEG) begin
               seg_off[idx - 1] = hdr_word;
               if (idx == 1 && hdr_word != dcmrle_pkg::HEADER_BYTES) begin
                  dropping = 1;
                  stage('0, '0, '0, dcmrle_pkg::ERR_FIRST_OFFSET);
                  return;
               end
            end
         end
         if (pos >= dcmrle_pkg::HEADER_BYTES - 1) begin
            phase    = PH_CONTROL;
            cur_seg  = '0;
            run_left = '0;
         end
      endfunction

      function void data_byte(logic [7:0] b);
         int          nxt;
         int unsigned left;
         int unsigned chunk;
         logic [31:0] word;
         // walk past every segment whose start is already behind us
         nxt = int'(cur_seg) + 1;
         while (nxt < seg_total && nxt < MAX_SEG && pos >= seg_off[nxt]) begin
            cur_seg  = nxt[3:0];
            nxt++;
            phase    = PH_CONTROL;
            run_left = '0;
         end
         case (phase)
            PH_CONTROL: begin
               if (b < 8'd128) begin
                  run_left = b + 8'd1;
                  phase    = PH_LITERAL;
               end else if (b > 8'd128) begin
                  run_left = 8'(257 - int'(b));
                  phase    = PH_REPEAT;
               end
            end
            PH_LITERAL: begin
               stage({24'h0, b}, 3'd1, cur_seg, dcmrle_pkg::ERR_NONE);
               run_left--;
               if (run_left == 0) phase = PH_CONTROL;
            end
            PH_REPEAT: begin
               left = run_left;
               while (left > 0) begin
                  chunk = (left < LANES) ? left : LANES;
                  word  = '0;
                  for (int i = 0; i < chunk; i++) word[8*i +: 8] = b;
                  stage(word, 3'(chunk), cur_seg, dcmrle_pkg::ERR_NONE);
                  left -= chunk;
               end
               run_left = '0;
               phase    = PH_CONTROL;
            end
            default: ;
         endcase
      endfunction

      function void take_byte(logic [7:0] b, logic last);
         if (!dropping) begin
            if (phase == PH_HEADER) header_byte(b);
            else data_byte(b);
         end
         if (pos != 32'hFFFF_FFFF) pos++;
         if (last && !held_valid) stage('0, '0, '0, dcmrle_pkg::ERR_NONE);
         if (held_valid) begin
            held.run_last   = 1'b1;
            held.frame_done = last;
            expected_words  = {expected_words, held};
            held_valid = 0;
         end
         if (last) clear_frame();
      endfunction

      function void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
         if (got_v !== exp_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            fail_count++;
         end
      endfunction

      function void check_word(dcmrle_pkg::rsp_type got);
         dcmrle_pkg::rsp_type exp_r;
         if (expected_words.size() == 0) begin
            $error("unexpected result transaction: data_word 0x%0h byte_count %0d",
                   got.data_word, got.byte_count);
            fail_count++;
            return;
         end
         exp_r = expected_words.pop_front();
         check_field("data_word", exp_r.data_word, got.data_word);
         check_field("byte_count", 32'(exp_r.byte_count), 32'(got.byte_count));
         check_field("segment_number", 32'(exp_r.segment_number),
                     32'(got.segment_number));
         check_field("error_code", 32'(exp_r.error_code), 32'(got.error_code));
         check_field("run_last", 32'(exp_r.run_last), 32'(got.run_last));
         check_field("frame_done", 32'(exp_r.frame_done), 32'(got.frame_done));
      endfunction
   endclass

   logic clock;
   logic reset;

   dcmrle_req_if req_ch ();
   dcmrle_rsp_if rsp_ch ();

   dicom_rle_frame_decoder_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   rle_frame_scoreboard sb = new();

   logic [7:0]  frame_q[$];
   logic [7:0]  data_q[$];
   logic [31:0] frame_offs [MAX_SEG];
   int          burst_left = 0;
   int          items_sent = 0;
   bit          hold_start = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // monitor: both channels sampled at the edge where the transaction happens
   always @(posedge clock) begin
      dcmrle_pkg::rsp_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.take_byte(req_ch.byte_value, req_ch.frame_last);
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.data_word      = rsp_ch.data_word;
            got.byte_count     = rsp_ch.byte_count;
            got.segment_number = rsp_ch.segment_number;
            got.error_code     = rsp_ch.error_code;
            got.run_last       = rsp_ch.run_last;
            got.frame_done     = rsp_ch.frame_done;
            sb.check_word(got);
         end
      end
   end

   // receiver backpressure: rotating patterns plus an on-demand long hold
   initial begin : rsp_stall_gen
      logic [31:0] cyc;
      int          hold_left;
      cyc       = '0;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         cyc++;
         if (hold_start) begin
            hold_start = 0;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (cyc[9:7])
               3'd0, 3'd1: rsp_ch.ready <= 1'b1;
               3'd2, 3'd3: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
               3'd4:       rsp_ch.ready <= (cyc[1:0] == 2'd0);
               3'd5:       rsp_ch.ready <= ($urandom_range(0, 1) == 0);
               default:    rsp_ch.ready <= cyc[2];
            endcase
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            gap        = 0;
            burst_left = $urandom_range(30, 60);
         end else begin
            gap        = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 12);
         end
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid      <= 1'b1;
      req_ch.byte_value <= b;
      req_ch.frame_last <= last;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   task automatic send_frame();
      for (int i = 0; i < frame_q.size(); i++)
         send_byte(frame_q[i], i == frame_q.size() - 1);
   endtask

   task automatic pause_until_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic put32(input logic [31:0] v);
      for (int i = 0; i < 4; i++) frame_q = {frame_q, v[8*i +: 8]};
   endtask

   task automatic pack_frame(input logic [31:0] count);
      frame_q.delete();
      put32(count);
      for (int i = 0; i < MAX_SEG; i++) put32(frame_offs[i]);
      frame_q = {frame_q, data_q};
   endtask

   // one segment's PackBits stream: literals, repeats, no-ops, some junk
   task automatic gen_body();
      int n_pkt;
      int len;
      n_pkt = $urandom_range(0, 4);
      for (int p = 0; p < n_pkt; p++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               len = ($urandom_range(0, 15) == 0) ? 128 : $urandom_range(1, 6);
               data_q = {data_q, 8'(len - 1)};
               for (int i = 0; i < len; i++) data_q = {data_q, 8'($urandom)};
            end
            4, 5, 6, 7: begin
               len = ($urandom_range(0, 7) == 0) ? 128 : $urandom_range(2, 12);
               data_q = {data_q, 8'(257 - len)};
               data_q = {data_q, 8'($urandom)};
            end
            8: data_q = {data_q, 8'h80};
            default: begin
               len = $urandom_range(1, 3);
               for (int i = 0; i < len; i++) data_q = {data_q, 8'($urandom)};
            end
         endcase
      end
   endtask

   task automatic build_valid(input int nseg, input bit scramble);
      int start;
      int next_off;
      int k;
      data_q.delete();
      next_off = dcmrle_pkg::HEADER_BYTES;
      for (int i = 0; i < MAX_SEG; i++) begin
         if (i < nseg) begin
            frame_offs[i] = next_off;
            start = data_q.size();
            gen_body();
            next_off += data_q.size() - start;
         end else begin
            frame_offs[i] = $urandom;
         end
      end
      // pull one start back so segments overlap or come out of order
      if (scramble && nseg > 1) begin
         k = $urandom_range(1, nseg - 1);
         frame_offs[k] = $urandom_range(0, frame_offs[k]);
      end
      pack_frame(nseg);
   endtask

   task automatic run_directed();
      // segment count zero, error on the closing byte
      frame_q = {8'h00, 8'h00, 8'h00, 8'h00};
      send_frame();
      // count 16, trailing bytes dropped
      frame_q = {8'h10, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00};
      send_frame();
      // count with top bit set
      frame_q = {8'h01, 8'h00, 8'h00, 8'h80, 8'h5A};
      send_frame();
      // first offset 0x10040
      frame_q = {8'h02, 8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h01, 8'h00, 8'h7F};
      send_frame();
      // first offset 65, frame closes on the error byte
      frame_q = {8'h0F, 8'h00, 8'h00, 8'h00, 8'h41, 8'h00, 8'h00, 8'h00};
      send_frame();
      // frames that end inside the header
      frame_q = {8'hFF};
      send_frame();
      frame_q = {8'h03, 8'h00, 8'h00};
      send_frame();

      // full 15-segment frame: literal 1 and 128, repeat 2 and 128, no-op,
      // empty segment, a start already passed, unfinished literal at the end
      data_q = {8'h00, 8'hA5, 8'h80, 8'h81, 8'h3C, 8'hFF, 8'hC3, 8'h7F};
      for (int i = 0; i < 128; i++) data_q = {data_q, 8'(i * 37 + 11)};
      data_q = {data_q, 8'h02, 8'h01, 8'h02, 8'h04};
      frame_offs[0] = dcmrle_pkg::HEADER_BYTES;
      frame_offs[1] = data_q.size() + dcmrle_pkg::HEADER_BYTES;
      data_q = {data_q, 8'hFE, 8'h55};
      frame_offs[2] = data_q.size() + dcmrle_pkg::HEADER_BYTES;
      frame_offs[3] = frame_offs[2];
      frame_offs[4] = 32'd10;
      for (int i = 5; i < MAX_SEG; i++) frame_offs[i] = 32'hFFFF_FFFF;
      data_q = {data_q, 8'h03, 8'h11, 8'h22, 8'h33, 8'h44};
      data_q = {data_q, 8'h05, 8'h00, 8'hFF};
      pack_frame(MAX_SEG);
      // long receiver hold on a busy frame so the command queue backs up
      hold_start = 1;
      send_frame();
   endtask

   initial begin : stimulus
      int          frame_no;
      int          nseg;
      int          cut;
      logic [31:0] v;
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.byte_value <= '0;
      req_ch.frame_last <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      pause_until_drained();

      frame_no = 0;
      while (items_sent < TOTAL_ITEMS) begin
         if (frame_no > 0 && $urandom_range(0, 4) == 0) pause_until_drained();
         nseg = ($urandom_range(0, 7) == 0) ? MAX_SEG : $urandom_range(1, 4);
         case ($urandom_range(0, 9))
            0: begin
               case ($urandom_range(0, 2))
                  0:       v = '0;
                  1:       v = $urandom_range(16, 255);
                  default: v = $urandom | 32'h100;
               endcase
               frame_q.delete();
               put32(v);
               repeat ($urandom_range(0, 5)) frame_q = {frame_q, 8'($urandom)};
            end
            1: begin
               frame_q.delete();
               put32($urandom_range(1, MAX_SEG));
               v = $urandom;
               if (v == dcmrle_pkg::HEADER_BYTES) v = v + 1;
               put32(v);
               repeat ($urandom_range(0, 5)) frame_q = {frame_q, 8'($urandom)};
            end
            2: begin
               build_valid(nseg, $urandom_range(0, 1));
               cut = $urandom_range(1, frame_q.size());
               while (frame_q.size() > cut) void'(frame_q.pop_back());
            end
            3: begin
               build_valid(nseg, 1'b0);
               for (int i = dcmrle_pkg::HEADER_BYTES; i < frame_q.size(); i++)
                  frame_q[i] = 8'($urandom);
            end
            default: build_valid(nseg, $urandom_range(0, 4) == 0);
         endcase
         send_frame();
         frame_no++;
      end

      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: sim.f
sv/dcmrle_pkg.sv
sv/dcmrle_if.sv
sv/dcmrle_front.sv
sv/dcmrle_queue.sv
sv/dcmrle_back.sv
sv/dicom_rle_frame_decoder_core.sv
dv/tb.sv
